// ----- rtl/urxf_pkg.sv -----
// Shared types and constants for the 8N1 receiver with receive ring.
// No dependencies; imported by every module of the block.
package urxf_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned DataW        = 8;
  localparam int unsigned FillW        = 6;
  localparam int unsigned TimerW       = 16;
  localparam int unsigned SampleW      = 4;

  localparam logic [TimerW-1:0]  BitPeriodRst   = 16'd868;
  localparam logic [TimerW-1:0]  FirstSampleRst = 16'd1302;
  // sample 8 completes the byte, sample 9 is the stop bit
  localparam logic [SampleW-1:0] LastDataSample = 4'd8;
  localparam logic [SampleW-1:0] StopSample     = 4'd9;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_READ = 2'd1,
    REQ_PEEK = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    REG_BIT_PERIOD   = 2'd0,
    REG_FIRST_SAMPLE = 2'd1,
    REG_RX_ENABLE    = 2'd2
  } reg_e;

  typedef struct packed {
    logic [TimerW-1:0] bit_period;
    logic [TimerW-1:0] first_sample;
    logic              rx_enable;
  } cfg_t;

  typedef struct packed {
    logic             push;
    logic [DataW-1:0] data;
  } rx_byte_t;

  typedef struct packed {
    logic query;  // read or peek word being processed
    logic pop;    // read: advance the read index if not empty
    logic clear;  // empty the ring
  } ring_cmd_t;

endpackage

// ----- rtl/urxf_rx.sv -----
// Serial bit receiver: start edge detect, bit timer and shift register.
// Depends on urxf_pkg.
module urxf_rx import urxf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     clear_i,
  input  logic     tick_i,
  input  logic     level_i,
  output rx_byte_t byte_o
);

  logic               last_level_q, last_level_d;
  logic               receiving_q, receiving_d;
  logic [SampleW-1:0] sample_count_q, sample_count_d;
  logic [TimerW-1:0]  countdown_q, countdown_d;
  logic [DataW-1:0]   shift_q, shift_d;

  logic [SampleW-1:0] sample_inc;
  logic [DataW-1:0]   shift_set;

  always_comb begin
    sample_inc = sample_count_q + 4'd1;
    shift_set  = shift_q;
    if (level_i && (sample_count_q < LastDataSample)) begin
      shift_set = shift_q | (8'd1 << sample_count_q[2:0]);
    end
  end

  always_comb begin
    last_level_d   = last_level_q;
    receiving_d    = receiving_q;
    sample_count_d = sample_count_q;
    countdown_d    = countdown_q;
    shift_d        = shift_q;
    byte_o.push    = 1'b0;
    byte_o.data    = shift_set;
    if (clear_i) begin
      receiving_d    = 1'b0;
      sample_count_d = '0;
      countdown_d    = '0;
      shift_d        = '0;
    end else if (tick_i) begin
      last_level_d = level_i;
      if (receiving_q) begin
        if (countdown_q <= 16'd1) begin
          countdown_d    = cfg_i.bit_period;
          shift_d        = shift_set;
          sample_count_d = sample_inc;
          if (sample_inc == LastDataSample) begin
            byte_o.push = 1'b1;
          end else if (sample_inc >= StopSample) begin
            receiving_d = 1'b0;
          end
        end else begin
          countdown_d = countdown_q - 16'd1;
        end
      end else if (cfg_i.rx_enable && last_level_q && !level_i) begin
        receiving_d    = 1'b1;
        sample_count_d = '0;
        shift_d        = '0;
        countdown_d    = cfg_i.first_sample;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q   <= 1'b1;
      receiving_q    <= 1'b0;
      sample_count_q <= '0;
      countdown_q    <= '0;
      shift_q        <= '0;
    end else begin
      last_level_q   <= last_level_d;
      receiving_q    <= receiving_d;
      sample_count_q <= sample_count_d;
      countdown_q    <= countdown_d;
      shift_q        <= shift_d;
    end
  end

endmodule

// ----- rtl/urxf_ring.sv -----
// Receive ring: byte memory, write/read indices and the result register.
// Depends on urxf_pkg.
module urxf_ring import urxf_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rx_byte_t         push_i,
  input  ring_cmd_t        cmd_i,
  output logic             byte_valid_o,
  output logic [FillW-1:0] fill_o,
  output logic [DataW-1:0] rdata_o
);

  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned FillX = (IdxW > FillW) ? IdxW : FillW;

  logic [DataW-1:0] mem [DEPTH];

  logic [IdxW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [IdxW-1:0]  wr_nxt, rd_nxt;
  logic             full, not_empty, do_pop;
  logic [IdxW:0]    fill_full;
  logic [FillX-1:0] fill_x;

  logic             byte_valid_q;
  logic [FillW-1:0] fill_q;
  logic [DataW-1:0] rdata_q;

  always_comb begin
    wr_nxt    = (wr_q == IdxW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    rd_nxt    = (rd_q == IdxW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    full      = (wr_nxt == rd_q);
    not_empty = (wr_q != rd_q);
    do_pop    = cmd_i.query && cmd_i.pop && not_empty;

    wr_d = wr_q;
    rd_d = rd_q;
    if (cmd_i.clear) begin
      wr_d = '0;
      rd_d = '0;
    end else begin
      if (push_i.push && !full) wr_d = wr_nxt;
      if (do_pop)               rd_d = rd_nxt;
    end

    // fill after this word, held below DEPTH
    if (wr_q >= rd_d) begin
      fill_full = {1'b0, wr_q} - {1'b0, rd_d};
    end else begin
      fill_full = (IdxW + 1)'(DEPTH) + {1'b0, wr_q} - {1'b0, rd_d};
    end
    fill_x = FillX'(fill_full[IdxW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push && !full && !cmd_i.clear) begin
      mem[wr_q] <= push_i.data;
    end
    if (cmd_i.query) begin
      rdata_q      <= mem[rd_q];
      byte_valid_q <= not_empty;
      fill_q       <= fill_x[FillW-1:0];
    end
  end

  assign byte_valid_o = byte_valid_q;
  assign fill_o       = fill_q;
  assign rdata_o      = byte_valid_q ? rdata_q : '0;

endmodule

// ----- rtl/uart_rx_with_ring_fifo_core.sv -----
// 8N1 serial receiver with receive ring. A read or peek word passes through
// the input register, then the result register with the registered ring read.
// Throughput: one word per cycle, ticks included, unless a query waits on the result.
// Reset: receiver idle with line seen high, ring empty, timing registers at
// 868/1302, reception disabled. Ring contents are undefined until written.
module uart_rx_with_ring_fifo_core import urxf_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] line_level, [7:1] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] byte_out, [13:8] fill_count, [15:14] zero
  output logic [0:0]  m_axis_tuser,   // [0] byte_valid
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q, cfg_d;
  logic cfg_wr, clear;

  logic       in_valid_q, in_valid_d;
  logic [1:0] in_req_q;
  logic       in_level_q;
  logic       out_valid_q, out_valid_d;

  logic is_query, out_free, fire, in_accept, tick;

  rx_byte_t         rx_byte;
  ring_cmd_t        ring_cmd;
  logic             byte_valid;
  logic [FillW-1:0] fill;
  logic [DataW-1:0] rdata;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign clear  = cfg_wr && (paddr[3:2] == REG_RX_ENABLE);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BIT_PERIOD:   cfg_d.bit_period   = pwdata[TimerW-1:0];
        REG_FIRST_SAMPLE: cfg_d.first_sample = pwdata[TimerW-1:0];
        REG_RX_ENABLE:    cfg_d.rx_enable    = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BIT_PERIOD:   prdata = {16'd0, cfg_q.bit_period};
      REG_FIRST_SAMPLE: prdata = {16'd0, cfg_q.first_sample};
      REG_RX_ENABLE:    prdata = {31'd0, cfg_q.rx_enable};
      default:          prdata = '0;
    endcase
  end

  // handshake: a query waits in the input register while the result is held
  assign is_query      = (in_req_q == REQ_READ) || (in_req_q == REQ_PEEK);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && (!is_query || out_free);
  assign s_axis_tready = !in_valid_q || fire;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign tick          = fire && (in_req_q == REQ_TICK);

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept)  in_valid_d = 1'b1;
    else if (fire)  in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (fire && is_query)    out_valid_d = 1'b1;
    else if (m_axis_tready)  out_valid_d = 1'b0;

    ring_cmd.query = fire && is_query;
    ring_cmd.pop   = (in_req_q == REQ_READ);
    ring_cmd.clear = clear;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period   <= BitPeriodRst;
      cfg_q.first_sample <= FirstSampleRst;
      cfg_q.rx_enable    <= 1'b0;
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_req_q   <= s_axis_tuser;
      in_level_q <= s_axis_tdata[0];
    end
  end

  urxf_rx u_rx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .clear_i (clear),
    .tick_i  (tick),
    .level_i (in_level_q),
    .byte_o  (rx_byte)
  );

  urxf_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (rx_byte),
    .cmd_i        (ring_cmd),
    .byte_valid_o (byte_valid),
    .fill_o       (fill),
    .rdata_o      (rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, fill, rdata};
  assign m_axis_tuser  = byte_valid;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for the 8N1 receiver with receive ring (uart_rx_with_ring_fifo_core).
// Needs urxf_pkg and the core RTL; the scoreboard class keeps its own copy of the receiver state.
`timescale 1ns / 100ps

import urxf_pkg::*;

class rx_ring_board #(int unsigned DEPTH = DepthDefault);

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             present;
    logic [FillW-1:0] fill;
  } reply_t;

  // register copies
  logic [TimerW-1:0]  bit_period;
  logic [TimerW-1:0]  first_delay;
  logic               rx_en;
  // receiver
  logic               last_lvl;
  logic               busy;
  logic [SampleW-1:0] n_samples;
  logic [TimerW-1:0]  countdown;
  logic [DataW-1:0]   shreg;
  // ring
  logic [DataW-1:0]   ring [DEPTH];
  int unsigned        wr_idx;
  int unsigned        rd_idx;

  reply_t             replies_q[$];
  int unsigned        mismatches;

  function new();
    bit_period  = BitPeriodRst;
    first_delay = FirstSampleRst;
    rx_en       = 1'b0;
    last_lvl    = 1'b1;
    busy        = 1'b0;
    n_samples   = '0;
    countdown   = '0;
    shreg       = '0;
    wr_idx      = 0;
    rd_idx      = 0;
    mismatches  = 0;
  endfunction

  function int unsigned ring_fill();
    return (wr_idx + DEPTH - rd_idx) % DEPTH;
  endfunction

  function int unsigned pending();
    return replies_q.size();
  endfunction

  function void write_reg(reg_e idx, logic [31:0] val);
    case (idx)
      REG_BIT_PERIOD:   bit_period  = val[TimerW-1:0];
      REG_FIRST_SAMPLE: first_delay = val[TimerW-1:0];
      REG_RX_ENABLE: begin
        // any write empties the ring and drops a reception in progress
        rx_en     = val[0];
        wr_idx    = 0;
        rd_idx    = 0;
        busy      = 1'b0;
        n_samples = '0;
        countdown = '0;
        shreg     = '0;
      end
      default: ;
    endcase
  endfunction

  function void take_sample(logic lvl);
    if (lvl && n_samples < LastDataSample) shreg[n_samples] = 1'b1;
    n_samples = n_samples + 1'b1;
    if (n_samples == LastDataSample) begin
      // full ring: byte lost without trace
      if ((wr_idx + 1) % DEPTH != rd_idx) begin
        ring[wr_idx] = shreg;
        wr_idx = (wr_idx + 1) % DEPTH;
      end
    end else if (n_samples >= StopSample) begin
      busy = 1'b0;
    end
  endfunction

  function void tick(logic lvl);
    if (busy) begin
      // a zero reload behaves as one
      if (countdown <= 1) begin
        countdown = bit_period;
        take_sample(lvl);
      end else begin
        countdown = countdown - 1'b1;
      end
    end else if (rx_en && last_lvl && !lvl) begin
      busy      = 1'b1;
      n_samples = '0;
      shreg     = '0;
      countdown = first_delay;
    end
    last_lvl = lvl;
  endfunction

  function void note_word(logic [1:0] req, logic lvl);
    reply_t r;
    case (req)
      REQ_TICK: tick(lvl);
      REQ_READ, REQ_PEEK: begin
        r = '0;
        if (wr_idx != rd_idx) begin
          r.data    = ring[rd_idx];
          r.present = 1'b1;
          if (req == REQ_READ) rd_idx = (rd_idx + 1) % DEPTH;
        end
        r.fill = FillW'(ring_fill());
        replies_q.push_back(r);
      end
      default: ;  // unused code is dropped
    endcase
  endfunction

  function void check_reply(logic [DataW-1:0] data, logic present, logic [FillW-1:0] fill);
    reply_t r;
    if (replies_q.size() == 0) begin
      $error("result word with no read or peek outstanding");
      mismatches++;
      return;
    end
    r = replies_q.pop_front();
    if (data !== r.data) begin
      $error("byte_out: expected %0h, got %0h", r.data, data);
      mismatches++;
    end
    if (present !== r.present) begin
      $error("byte_valid: expected %0d, got %0d", r.present, present);
      mismatches++;
    end
    if (fill !== r.fill) begin
      $error("fill_count: expected %0d, got %0d", r.fill, fill);
      mismatches++;
    end
  endfunction

endclass

module tb_top;

  localparam int unsigned RING_DEPTH     = 64;
  localparam int unsigned RAND_WORDS     = 100;
  localparam int unsigned PIPE_FLUSH     = 4;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [1:0]  REQ_UNUSED     = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] line_level, [7:1] zero
  logic [1:0]  s_axis_tuser;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] byte_out, [13:8] fill_count, [15:14] zero
  logic [0:0]  m_axis_tuser;   // [0] byte_valid
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rx_ring_board #(RING_DEPTH) board;

  int unsigned idle_cycles;
  int unsigned words_sent;
  int unsigned calm_words;
  bit          strays_on;

  uart_rx_with_ring_fifo_core #(.DEPTH(RING_DEPTH)) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // accepted words go to the board; result check first so a word accepted now
  // cannot be mistaken for the one leaving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_reply(m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tdata[13:8]);
      if (s_axis_tvalid && s_axis_tready)
        board.note_word(s_axis_tuser, s_axis_tdata[0]);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side back-pressure
  initial begin
    int unsigned hold;
    int unsigned calm;
    int unsigned pause;
    hold = 0;
    calm = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
      end else if (calm != 0) begin
        calm--;
        m_axis_tready <= 1'b1;
      end else begin
        pause = pick_pause();
        if (pause == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          hold = pause - 1;
        end
        if ($urandom_range(0, 199) == 0) calm = $urandom_range(50, 200);
      end
    end
  end

  task automatic send_word(input logic [1:0] req, input logic lvl);
    int unsigned gap;
    gap = 0;
    if (calm_words != 0) begin
      calm_words--;
    end else begin
      gap = pick_pause();
      if ($urandom_range(0, 99) == 0) calm_words = $urandom_range(30, 150);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {7'd0, lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_stray();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5)      send_word(REQ_READ, 1'($urandom_range(0, 1)));
    else if (r < 9) send_word(REQ_PEEK, 1'($urandom_range(0, 1)));
    else            send_word(REQ_UNUSED, 1'($urandom_range(0, 1)));
  endtask

  // idle-high lead-in, start bit, eight data bits LSB first, stop bit; each bit
  // held for blen ticks. A broken frame has glitches and may be cut short.
  task automatic send_frame(input logic [7:0] val, input int unsigned blen, input bit broken);
    logic [9:0]  bits;
    int unsigned nbits;
    logic        lvl;
    bits  = {1'b1, val, 1'b0};
    nbits = broken ? $urandom_range(1, 10) : 10;
    repeat ($urandom_range(1, 3)) send_word(REQ_TICK, 1'b1);
    for (int i = 0; i < nbits; i++) begin
      for (int j = 0; j < blen; j++) begin
        lvl = bits[i];
        if (broken && $urandom_range(0, 5) == 0) lvl = ~lvl;
        if (strays_on && $urandom_range(0, 11) == 0) send_stray();
        send_word(REQ_TICK, lvl);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (PIPE_FLUSH) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [15:0] period, input logic [15:0] first_delay,
                             input logic en, input bit touch_enable);
    drain();
    reg_write(REG_BIT_PERIOD, {16'd0, period});
    reg_write(REG_FIRST_SAMPLE, {16'd0, first_delay});
    if (touch_enable) reg_write(REG_RX_ENABLE, {31'd0, en});
  endtask

  task automatic run_phase(input int unsigned actions, input int unsigned blen);
    int unsigned r;
    int unsigned len;
    repeat (actions) begin
      r   = $urandom_range(0, 99);
      len = blen;
      if ($urandom_range(0, 9) == 0) len = blen + 1;
      else if ($urandom_range(0, 9) == 0 && blen > 1) len = blen - 1;
      if (r < 55)      send_frame(8'($urandom), len, 1'b0);
      else if (r < 62) send_frame(8'($urandom), len, 1'b1);
      else if (r < 77) send_word(REQ_READ, 1'($urandom_range(0, 1)));
      else if (r < 85) send_word(REQ_PEEK, 1'($urandom_range(0, 1)));
      else if (r < 90) repeat ($urandom_range(1, 6)) send_word(REQ_TICK, 1'($urandom_range(0, 1)));
      else if (r < 94) send_word(REQ_UNUSED, 1'($urandom_range(0, 1)));
      else repeat ($urandom_range(3, 10)) send_word(REQ_READ, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned start_words;
    int unsigned kind;
    logic [15:0] period;
    logic [15:0] first_delay;
    int unsigned blen;
    board      = new();
    words_sent = 0;
    calm_words = 0;
    strays_on  = 1'b1;
    rst_ni         = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_TICK;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty ring, unused code, and an edge the disabled receiver must ignore
    send_word(REQ_PEEK, 1'b1);
    send_word(REQ_READ, 1'b0);
    send_word(REQ_UNUSED, 1'b0);
    send_word(REQ_UNUSED, 1'b1);
    send_word(REQ_TICK, 1'b1);
    send_word(REQ_TICK, 1'b0);
    send_word(REQ_TICK, 1'b1);
    // widest timing: reception starts but never gets to a sample
    reconfigure(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_word(REQ_TICK, 1'b1);
    send_word(REQ_TICK, 1'b0);
    send_word(REQ_TICK, 1'b1);
    send_word(REQ_PEEK, 1'b0);
    // zero timing acts as one tick; enable write aborts the pending reception
    reconfigure(16'd0, 16'd0, 1'b1, 1'b1);
    send_frame(8'hA5, 1, 1'b0);
    send_word(REQ_PEEK, 1'b1);
    send_word(REQ_READ, 1'b0);

    start_words = words_sent;

    // overrun: one frame more than the ring holds, then read it dry
    reconfigure(16'd1, 16'd1, 1'b1, 1'b1);
    strays_on = 1'b0;
    repeat (RING_DEPTH) send_frame(8'($urandom), 1, 1'b0);
    send_word(REQ_PEEK, 1'b0);
    repeat (RING_DEPTH + 2) begin
      if ($urandom_range(0, 7) == 0) send_word(REQ_PEEK, 1'($urandom_range(0, 1)));
      send_word(REQ_READ, 1'($urandom_range(0, 1)));
    end
    strays_on = 1'b1;

    start_words = words_sent;

    while (words_sent - start_words < RAND_WORDS) begin
      kind   = $urandom_range(0, 9);
      period = 16'($urandom_range(1, ($urandom_range(0, 9) == 0) ? 16 : 6));
      if ($urandom_range(0, 9) < 7) first_delay = period + period / 2;
      else first_delay = 16'($urandom_range(1, 2 * period + 1));
      blen = period;
      if (kind < 6) begin
        reconfigure(period, first_delay, 1'b1, 1'b1);
      end else if (kind < 8) begin
        // timing changed under a live receiver and a filled ring
        reconfigure(period, first_delay, 1'b0, 1'b0);
      end else if (kind == 8) begin
        reconfigure(period, first_delay, 1'b0, 1'b1);
      end else begin
        period      = 16'd0;
        first_delay = 16'($urandom_range(0, 2));
        blen        = 1;
        reconfigure(period, first_delay, 1'b1, 1'b1);
      end
      run_phase($urandom_range(3, 10), blen);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
